// ===== sv/hsg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsg_pkg: shared types and constants of the history score table
// Command codes, the request type carried from front to back, and the
// fixed field widths of the stream and configuration ports.
// ----------------------------------------------------------------------------
package hsg_pkg;

	typedef enum logic [1:0] {
		CMD_READ     = 2'd0,
		CMD_REWARD   = 2'd1,
		CMD_PENALIZE = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	localparam int DEPTH_W = 7;
	localparam int SQ_W    = 2 * DEPTH_W;
	localparam int CFG_W   = 8;
	localparam int SCORE_W = 16;
	localparam int IN_W    = 32;
	localparam int PIECE_W = 3;
	localparam int SQR_W   = 6;
	// Products: |score| * bonus magnitude and the scaled penalty both fit
	// DIV_W bits. The divider takes the penalty numerator as its divisor.
	localparam int DIV_W   = 31;
	localparam int DVR_W   = 16;
	localparam int BMAG_W  = 15;
	localparam int SUM_W   = 19;
	// Reciprocal of a score limit of at least 256, scaled by 2^DIV_W.
	localparam int RCP_W   = 24;
	localparam int RP_W    = DIV_W + RCP_W;
	localparam int PULL_W  = SCORE_W + 1;
	localparam int QDEPTH  = 2;

	localparam logic CFG_PENALTY_NUM = 1'b0;
	localparam logic CFG_PENALTY_DEN = 1'b1;

	typedef struct packed {
		cmd_t            cmd;
		logic [SQ_W-1:0] sq;
	} op_t;

	localparam int OP_W = $bits(op_t);

endpackage

// ===== sv/history_score_table_gravity.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// history_score_table_gravity: signed score table with gravity updates
// Read, reward, penalize and clear requests on a table of 16-bit scores.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole table to zero, one entry per cycle,
// over all 2*PIECE_CODES*SQUARES*PIECE_CODES*SQUARES entries (524288 at the
// defaults), and takes no request before that sweep ends. A request passes
// the three front stages and the queue; a clear runs the same sweep in the
// back and then answers. The back handles one request at a time: each
// update makes one single-port read and one write of the score memory, the
// penalty scaling runs through a divider that yields one quotient bit per
// cycle, and the gravity pull is a multiplication by the reciprocal of the
// score limit with one correction step. The front keeps taking requests
// into a two-entry queue while the back works, and a finished score waits
// in an output register; while that score is not taken the back holds the
// next one. Write the registers only while no request is in flight; the
// block itself does not enforce it.
module history_score_table_gravity #(
	parameter int PIECE_CODES = 8,
	parameter int SQUARES     = 64,
	parameter int MAX_SCORE   = 16384
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// command[1:0], side[2], prev_piece[5:3], prev_to_square[11:6],
	// reply_piece[14:12], reply_to_square[20:15], depth[27:21], zero above
	input  logic [hsg_pkg::IN_W-1:0]      s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// score[15:0]
	output logic [hsg_pkg::SCORE_W-1:0]   m_axis_tdata,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [hsg_pkg::CFG_W-1:0]     cfg_data
);

	localparam int ENTRIES = 2 * PIECE_CODES * SQUARES * PIECE_CODES * SQUARES;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int QW      = ADDR_W + hsg_pkg::OP_W;

	logic [hsg_pkg::CFG_W-1:0] penalty_num_q, penalty_den_q;
	logic                      back_ready;
	logic                      f_valid, f_ready;
	hsg_pkg::op_t              f_op;
	logic [ADDR_W-1:0]         f_index;
	logic                      q_valid, q_pop;
	logic [QW-1:0]             q_data;
	hsg_pkg::op_t              q_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			penalty_num_q <= hsg_pkg::CFG_W'(1);
			penalty_den_q <= hsg_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == hsg_pkg::CFG_PENALTY_NUM) begin
				penalty_num_q <= cfg_data;
			end else begin
				penalty_den_q <= cfg_data;
			end
		end
	end

	hsg_front #(
		.PIECE_CODES (PIECE_CODES),
		.SQUARES     (SQUARES),
		.ADDR_W      (ADDR_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (back_ready),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_op    (f_op),
		.out_index (f_index)
	);

	hsg_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.not_full  (f_ready),
		.push_data ({f_index, f_op}),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	assign q_op = hsg_pkg::op_t'(q_data[hsg_pkg::OP_W-1:0]);

	hsg_back #(
		.MAX_SCORE (MAX_SCORE),
		.ENTRIES   (ENTRIES),
		.ADDR_W    (ADDR_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (q_valid),
		.req_pop     (q_pop),
		.req_op      (q_op),
		.req_index   (q_data[QW-1:hsg_pkg::OP_W]),
		.penalty_num (penalty_num_q),
		.penalty_den (penalty_den_q),
		.ready       (back_ready),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res_score   (m_axis_tdata)
	);

endmodule

// ===== sv/hsg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsg_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hsg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hsg_pkg::DIV_W-1:0]   dividend,
	input  logic [hsg_pkg::DVR_W-1:0]   divisor,
	output logic                        done,
	output logic [hsg_pkg::DIV_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(hsg_pkg::DIV_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [hsg_pkg::DVR_W-1:0]   rem_q;
	logic [hsg_pkg::DVR_W-1:0]   dvr_q;
	logic [hsg_pkg::DIV_W-1:0]   quo_q;
	logic [hsg_pkg::DVR_W:0]     rem_sh;
	logic [hsg_pkg::DVR_W:0]     rem_sub;
	logic                        qbit;

	always_comb begin
		rem_sh  = {rem_q, quo_q[hsg_pkg::DIV_W-1]};
		rem_sub = rem_sh - {1'b0, dvr_q};
		qbit    = (rem_sh >= {1'b0, dvr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(hsg_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			// The remainder stays below the divisor, so it fits DVR_W bits.
			rem_q <= qbit ? rem_sub[hsg_pkg::DVR_W-1:0] : rem_sh[hsg_pkg::DVR_W-1:0];
			quo_q <= {quo_q[hsg_pkg::DIV_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/hsg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsg_front: request intake and table index build
// Unpacks a request, saturates the index parts, builds the mixed-radix
// table index over three stages and squares the depth.
// ----------------------------------------------------------------------------
module hsg_front #(
	parameter int PIECE_CODES = 8,
	parameter int SQUARES     = 64,
	parameter int ADDR_W      = 19
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       enable,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [hsg_pkg::IN_W-1:0]   in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output hsg_pkg::op_t               out_op,
	output logic [ADDR_W-1:0]          out_index
);

	logic                         valid_s1, valid_s2, valid_s3;
	logic                         adv1, adv2, adv3;
	hsg_pkg::op_t                 op_s1, op_s2, op_s3;
	logic [ADDR_W-1:0]            hi_s1, lo_s1, psq_s1;
	logic [ADDR_W-1:0]            hi_s2, lo_s2;
	logic [ADDR_W-1:0]            index_s3;

	logic [1:0]                   f_cmd;
	logic                         f_side;
	logic [hsg_pkg::PIECE_W-1:0]  f_prev_piece, f_reply_piece;
	logic [hsg_pkg::SQR_W-1:0]    f_prev_sq, f_reply_sq;
	logic [hsg_pkg::DEPTH_W-1:0]  f_depth;
	logic [ADDR_W-1:0]            pp_sat, rp_sat, ps_sat, rs_sat;

	// tdata: command, side, prev_piece, prev_to_square, reply_piece,
	// reply_to_square, depth from bit 0 up.
	always_comb begin
		f_cmd         = in_data[1:0];
		f_side        = in_data[2];
		f_prev_piece  = in_data[5:3];
		f_prev_sq     = in_data[11:6];
		f_reply_piece = in_data[14:12];
		f_reply_sq    = in_data[20:15];
		f_depth       = in_data[27:21];

		pp_sat = (32'(f_prev_piece) >= PIECE_CODES) ? ADDR_W'(PIECE_CODES - 1)
			: ADDR_W'(f_prev_piece);
		rp_sat = (32'(f_reply_piece) >= PIECE_CODES) ? ADDR_W'(PIECE_CODES - 1)
			: ADDR_W'(f_reply_piece);
		ps_sat = (32'(f_prev_sq) >= SQUARES) ? ADDR_W'(SQUARES - 1) : ADDR_W'(f_prev_sq);
		rs_sat = (32'(f_reply_sq) >= SQUARES) ? ADDR_W'(SQUARES - 1) : ADDR_W'(f_reply_sq);
	end

	assign adv3     = !valid_s3 || out_ready;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1 && enable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid && enable;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			op_s1.cmd <= hsg_pkg::cmd_t'(f_cmd);
			op_s1.sq  <= hsg_pkg::SQ_W'(f_depth) * hsg_pkg::SQ_W'(f_depth);
			hi_s1     <= ADDR_W'(f_side) * ADDR_W'(PIECE_CODES) + pp_sat;
			lo_s1     <= rp_sat * ADDR_W'(SQUARES) + rs_sat;
			psq_s1    <= ps_sat;
		end
		if (adv2) begin
			op_s2 <= op_s1;
			hi_s2 <= hi_s1 * ADDR_W'(SQUARES) + psq_s1;
			lo_s2 <= lo_s1;
		end
		if (adv3) begin
			op_s3    <= op_s2;
			index_s3 <= hi_s2 * ADDR_W'(PIECE_CODES * SQUARES) + lo_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_op    = op_s3;
	assign out_index = index_s3;

endmodule

// ===== sv/hsg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsg_queue: short request queue between front and back
// A small first-in first-out buffer of QDEPTH entries.
// ----------------------------------------------------------------------------
module hsg_queue #(
	parameter int WIDTH = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             not_full,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(hsg_pkg::QDEPTH);
	localparam int CNT_W = $clog2(hsg_pkg::QDEPTH + 1);

	logic [WIDTH-1:0] slot_q [hsg_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign not_full  = (count_q != CNT_W'(hsg_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(hsg_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(hsg_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== sv/hsg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsg_back: score table and update sequencer
// Holds the score memory, runs the clearing sweep, the penalty scaling and
// the gravity read-modify-write, and registers the result.
// ----------------------------------------------------------------------------
module hsg_back #(
	parameter int MAX_SCORE = 16384,
	parameter int ENTRIES   = 524288,
	parameter int ADDR_W    = 19
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_pop,
	input  hsg_pkg::op_t                   req_op,
	input  logic [ADDR_W-1:0]              req_index,
	input  logic [hsg_pkg::CFG_W-1:0]      penalty_num,
	input  logic [hsg_pkg::CFG_W-1:0]      penalty_den,
	output logic                           ready,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [hsg_pkg::SCORE_W-1:0]    res_score
);

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_CLEAR, ST_PDIV, ST_PWAIT, ST_RD, ST_RWAIT,
		ST_GMUL, ST_GREM, ST_GFIX, ST_GSUM, ST_WR, ST_OUT
	} state_t;

	localparam logic [ADDR_W-1:0]           LAST_ADDR = ADDR_W'(ENTRIES - 1);
	localparam logic [hsg_pkg::BMAG_W-1:0]  MAX_MAG   = hsg_pkg::BMAG_W'(MAX_SCORE);
	localparam logic signed [hsg_pkg::SUM_W-1:0] MAX_POS = hsg_pkg::SUM_W'(MAX_SCORE);
	localparam logic signed [hsg_pkg::SUM_W-1:0] MAX_NEG = -hsg_pkg::SUM_W'(MAX_SCORE);
	localparam logic [hsg_pkg::RCP_W-1:0]   RECIP     =
		hsg_pkg::RCP_W'((64'd1 << hsg_pkg::DIV_W) / MAX_SCORE);

	state_t                               state_q;
	hsg_pkg::cmd_t                        cmd_q;
	logic [ADDR_W-1:0]                    index_q;
	logic [ADDR_W-1:0]                    clr_addr_q;
	logic [hsg_pkg::BMAG_W-1:0]           bmag_q;
	logic [hsg_pkg::DIV_W-1:0]            prod_q;
	logic [hsg_pkg::RCP_W-1:0]            q0_q;
	logic [hsg_pkg::DIV_W-1:0]            rem_q;
	logic [hsg_pkg::PULL_W-1:0]           pull_q;
	logic signed [hsg_pkg::SCORE_W-1:0]   cur_q;
	logic signed [hsg_pkg::SCORE_W-1:0]   res_q;
	logic                                 out_valid_q;
	logic [hsg_pkg::SCORE_W-1:0]          out_score_q;

	logic signed [hsg_pkg::SCORE_W-1:0]   mem [ENTRIES];
	logic signed [hsg_pkg::SCORE_W-1:0]   mem_rdata_q;
	logic                                 mem_we;
	logic [ADDR_W-1:0]                    mem_addr;
	logic signed [hsg_pkg::SCORE_W-1:0]   mem_wdata;

	logic                                 div_start, div_done;
	logic [hsg_pkg::DVR_W-1:0]            div_divisor;
	logic [hsg_pkg::DIV_W-1:0]            div_quotient;
	logic [hsg_pkg::CFG_W-1:0]            num_eff;
	logic                                 out_free;

	logic [hsg_pkg::DIV_W-1:0]            pen;
	logic [hsg_pkg::BMAG_W-1:0]           pen_mag, rew_mag;
	logic [hsg_pkg::RP_W-1:0]             rcp_prod;
	logic signed [hsg_pkg::SUM_W-1:0]     cur_x, bonus_x, pull_x, sum_x, clamp_x;

	assign num_eff  = (penalty_num == '0) ? hsg_pkg::CFG_W'(1) : penalty_num;
	assign out_free = !out_valid_q || res_ready;

	always_comb begin
		req_pop     = (state_q == ST_IDLE) && req_valid;
		div_start   = (state_q == ST_PDIV);
		div_divisor = hsg_pkg::DVR_W'(num_eff);
		mem_we      = (state_q == ST_INIT) || (state_q == ST_CLEAR) || (state_q == ST_WR);
		mem_addr    = ((state_q == ST_INIT) || (state_q == ST_CLEAR)) ? clr_addr_q : index_q;
		mem_wdata   = (state_q == ST_WR) ? res_q : '0;
	end

	always_comb begin
		// A penalty is never below one and no bonus exceeds the score limit.
		pen     = (div_quotient == '0) ? hsg_pkg::DIV_W'(1) : div_quotient;
		pen_mag = (pen > hsg_pkg::DIV_W'(MAX_SCORE)) ? MAX_MAG : pen[hsg_pkg::BMAG_W-1:0];
		rew_mag = ({1'b0, req_op.sq} > MAX_MAG) ? MAX_MAG
			: hsg_pkg::BMAG_W'(req_op.sq);

		// The reciprocal estimate of |cur| * |b| / MAX_SCORE is low by at most
		// one; the remainder check afterwards adds that one back.
		rcp_prod = hsg_pkg::RP_W'(prod_q) * hsg_pkg::RP_W'(RECIP);

		// Gravity: cur + b - trunc(cur * |b| / MAX_SCORE), rounding toward zero.
		cur_x   = hsg_pkg::SUM_W'(cur_q);
		bonus_x = (cmd_q == hsg_pkg::CMD_PENALIZE) ? -hsg_pkg::SUM_W'({1'b0, bmag_q})
			: hsg_pkg::SUM_W'({1'b0, bmag_q});
		pull_x  = cur_q[hsg_pkg::SCORE_W-1]
			? -hsg_pkg::SUM_W'({1'b0, pull_q})
			: hsg_pkg::SUM_W'({1'b0, pull_q});
		sum_x   = cur_x + bonus_x - pull_x;
		if (sum_x > MAX_POS) begin
			clamp_x = MAX_POS;
		end else if (sum_x < MAX_NEG) begin
			clamp_x = MAX_NEG;
		end else begin
			clamp_x = sum_x;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		mem_rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
					clr_addr_q <= clr_addr_q + 1'b1;
				end
				ST_IDLE: begin
					if (req_valid) begin
						cmd_q   <= req_op.cmd;
						index_q <= req_index;
						unique case (req_op.cmd)
							hsg_pkg::CMD_CLEAR: begin
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end
							hsg_pkg::CMD_READ: begin
								state_q <= ST_RD;
							end
							hsg_pkg::CMD_REWARD: begin
								bmag_q  <= rew_mag;
								state_q <= ST_RD;
							end
							hsg_pkg::CMD_PENALIZE: begin
								prod_q  <= hsg_pkg::DIV_W'(req_op.sq) * hsg_pkg::DIV_W'(penalty_den);
								state_q <= ST_PDIV;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLEAR: begin
					if (clr_addr_q == LAST_ADDR) begin
						res_q   <= '0;
						state_q <= ST_OUT;
					end
					clr_addr_q <= clr_addr_q + 1'b1;
				end
				ST_PDIV: state_q <= ST_PWAIT;
				ST_PWAIT: begin
					if (div_done) begin
						bmag_q  <= pen_mag;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_RWAIT;
				ST_RWAIT: begin
					cur_q <= mem_rdata_q;
					if (cmd_q == hsg_pkg::CMD_READ) begin
						res_q   <= mem_rdata_q;
						state_q <= ST_OUT;
					end else begin
						prod_q  <= hsg_pkg::DIV_W'(mem_rdata_q[hsg_pkg::SCORE_W-1]
							? hsg_pkg::SCORE_W'(-mem_rdata_q) : hsg_pkg::SCORE_W'(mem_rdata_q))
							* hsg_pkg::DIV_W'(bmag_q);
						state_q <= ST_GMUL;
					end
				end
				ST_GMUL: begin
					q0_q    <= rcp_prod[hsg_pkg::RP_W-1:hsg_pkg::DIV_W];
					state_q <= ST_GREM;
				end
				ST_GREM: begin
					rem_q   <= prod_q - hsg_pkg::DIV_W'(q0_q) * hsg_pkg::DIV_W'(MAX_SCORE);
					state_q <= ST_GFIX;
				end
				ST_GFIX: begin
					pull_q  <= hsg_pkg::PULL_W'(q0_q)
						+ hsg_pkg::PULL_W'(rem_q >= hsg_pkg::DIV_W'(MAX_SCORE));
					state_q <= ST_GSUM;
				end
				ST_GSUM: begin
					res_q   <= hsg_pkg::SCORE_W'(clamp_x);
					state_q <= ST_WR;
				end
				ST_WR: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						out_score_q <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	hsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign ready     = (state_q != ST_INIT);
	assign res_valid = out_valid_q;
	assign res_score = out_score_q;

endmodule
